>>> hw/rtl/rgbup_pkg.sv
// ----------------------------------------------------------------------------
// rgbup_pkg
// Shared constants, command/status structs and state type for the
// RGB565 integer upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbup_pkg;

   localparam int DISPLAY_WIDTH  = 1024;
   localparam int DISPLAY_HEIGHT = 512;
   localparam int MAX_SCALE      = 8;

   localparam int SRC_W_BITS    = 11;
   localparam int SRC_H_BITS    = 10;
   localparam int X_BITS        = 10;
   localparam int Y_BITS        = 9;
   localparam int SCALE_BITS    = 4;
   localparam int OFS_BITS      = 3;
   localparam int MULT_BITS     = 16;
   localparam int PIX_BITS      = 16;
   localparam int COLOR_BITS    = 24;
   localparam int RSP_DATA_BITS = 48;
   localparam int RSP_USER_BITS = 3;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 11;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_HEIGHT = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_BASE,
      ST_POS,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic load_pixel;
      logic calc_scale;
      logic calc_base;
      logic calc_pos;
      logic emit;
      logic emit_err;
   } cmd_type;

   typedef struct packed {
      logic frame_start;
      logic geom_bad;
      logic emit_final;
      logic slot_free;
   } sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/rgbup_datapath.sv
// ----------------------------------------------------------------------------
// rgbup_datapath
// Geometry registers, scale and offset calculation, source position
// counters, write-address generation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbup_datapath
   import rgbup_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic [PIX_BITS-1:0]      req_tdata,
   input  wire logic                     rsp_tready,
   output logic                          rsp_tvalid,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,   // write_x, write_y, color_out
   output logic [RSP_USER_BITS-1:0]      rsp_tuser,   // buffer_select, error_flag, frame_done
   output logic                          rsp_tlast,
   input  wire cmd_type                  cmd,
   output sts_type                       sts
);

   logic [SRC_W_BITS-1:0] width_ff, width_in;
   logic [SRC_H_BITS-1:0] height_ff, height_in;
   logic [X_BITS-1:0]     col_ff, col_in;
   logic [Y_BITS-1:0]     row_ff, row_in;
   logic                  bb_ff, bb_in;
   logic [SCALE_BITS-1:0] scale_ff, scale_in;
   logic [X_BITS-1:0]     base_x_ff, base_x_in;
   logic [Y_BITS-1:0]     base_y_ff, base_y_in;
   logic [X_BITS-1:0]     bx_ff, bx_in;
   logic [Y_BITS-1:0]     by_ff, by_in;
   logic [OFS_BITS-1:0]   dx_ff, dx_in;
   logic [OFS_BITS-1:0]   dy_ff, dy_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   logic                     out_valid_ff, out_valid_in;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   logic [RSP_USER_BITS-1:0] out_user_ff, out_user_in;
   logic                     out_last_ff, out_last_in;

   logic [SCALE_BITS-1:0] fit_count;
   logic [MULT_BITS-1:0]  xprod, yprod;
   logic [MULT_BITS-1:0]  xpos_prod, ypos_prod;
   logic                  col_end, row_end;
   logic                  dx_end, dy_end;
   logic [4:0]            r5, b5;
   logic [5:0]            g6;

   // largest scale whose scaled image still fits both display dimensions
   always_comb begin
      fit_count = '0;
      for (int i = 1; i <= MAX_SCALE; i++) begin
         if ((MULT_BITS'(width_ff) * MULT_BITS'(i) <= MULT_BITS'(DISPLAY_WIDTH)) &&
             (MULT_BITS'(height_ff) * MULT_BITS'(i) <= MULT_BITS'(DISPLAY_HEIGHT))) begin
            fit_count = fit_count + SCALE_BITS'(1);
         end
      end
   end

   assign xprod     = MULT_BITS'(width_ff) * MULT_BITS'(scale_ff);
   assign yprod     = MULT_BITS'(height_ff) * MULT_BITS'(scale_ff);
   assign xpos_prod = MULT_BITS'(col_ff) * MULT_BITS'(scale_ff);
   assign ypos_prod = MULT_BITS'(row_ff) * MULT_BITS'(scale_ff);

   assign col_end = (SRC_W_BITS'(col_ff) + SRC_W_BITS'(1)) >= width_ff;
   assign row_end = (SRC_H_BITS'(row_ff) + SRC_H_BITS'(1)) >= height_ff;
   assign dx_end  = (SCALE_BITS'(dx_ff) + SCALE_BITS'(1)) == scale_ff;
   assign dy_end  = (SCALE_BITS'(dy_ff) + SCALE_BITS'(1)) == scale_ff;

   assign r5 = req_tdata[15:11];
   assign g6 = req_tdata[10:5];
   assign b5 = req_tdata[4:0];

   assign sts.frame_start = (col_ff == '0) && (row_ff == '0);
   assign sts.geom_bad    = (width_ff == '0) || (height_ff == '0) || (fit_count == '0);
   assign sts.emit_final  = dx_end && dy_end;
   assign sts.slot_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      bb_in     = bb_ff;
      scale_in  = scale_ff;
      base_x_in = base_x_ff;
      base_y_in = base_y_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      color_in  = color_ff;

      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;

      if (csr_we) begin
         if (csr_index == CSR_SRC_WIDTH) begin
            width_in = csr_wdata;
            col_in   = '0;
            row_in   = '0;
         end else if (csr_index == CSR_SRC_HEIGHT) begin
            height_in = csr_wdata[SRC_H_BITS-1:0];
            col_in    = '0;
            row_in    = '0;
         end
      end

      if (cmd.load_pixel) begin
         color_in = {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
      end

      if (cmd.calc_scale) begin
         scale_in = fit_count;
      end

      if (cmd.calc_base) begin
         base_x_in = X_BITS'((MULT_BITS'(DISPLAY_WIDTH) - xprod) >> 1);
         base_y_in = Y_BITS'((MULT_BITS'(DISPLAY_HEIGHT) - yprod) >> 1);
      end

      if (cmd.calc_pos) begin
         bx_in = base_x_ff + xpos_prod[X_BITS-1:0];
         by_in = base_y_ff + ypos_prod[Y_BITS-1:0];
         dx_in = '0;
         dy_in = '0;
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_data_in  = RSP_DATA_BITS'({color_ff,
                                        by_ff + Y_BITS'(dy_ff),
                                        bx_ff + X_BITS'(dx_ff)});
         out_user_in  = {sts.emit_final && col_end && row_end, 1'b0, bb_ff};
         out_last_in  = sts.emit_final;
         if (dx_end) begin
            dx_in = '0;
            dy_in = dy_ff + OFS_BITS'(1);
         end else begin
            dx_in = dx_ff + OFS_BITS'(1);
         end
         if (sts.emit_final) begin
            if (col_end) begin
               col_in = '0;
               if (row_end) begin
                  row_in = '0;
                  bb_in  = !bb_ff;
               end else begin
                  row_in = row_ff + Y_BITS'(1);
               end
            end else begin
               col_in = col_ff + X_BITS'(1);
            end
         end
      end

      if (cmd.emit_err) begin
         out_valid_in = 1'b1;
         out_data_in  = '0;
         out_user_in  = {1'b0, 1'b1, bb_ff};
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= '0;
         height_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         bb_ff        <= 1'b1;
         scale_ff     <= '0;
         base_x_ff    <= '0;
         base_y_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         bb_ff        <= bb_in;
         scale_ff     <= scale_in;
         base_x_ff    <= base_x_in;
         base_y_ff    <= base_y_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      color_ff    <= color_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rgbup_ctrl.sv
// ----------------------------------------------------------------------------
// rgbup_ctrl
// Sequencer: pixel accept, frame setup, block position, write loop and error write.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbup_ctrl
   import rgbup_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.frame_start ? ST_SCALE : ST_POS;
            end
         end
         ST_SCALE: begin
            state_in = sts.geom_bad ? ST_ERROR : ST_BASE;
         end
         ST_BASE: begin
            state_in = ST_POS;
         end
         ST_POS: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.slot_free && sts.emit_final) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERROR: begin
            if (sts.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.load_pixel = req_tvalid;
         end
         ST_SCALE: begin
            cmd.calc_scale = !sts.geom_bad;
         end
         ST_BASE: begin
            cmd.calc_base = 1'b1;
         end
         ST_POS: begin
            cmd.calc_pos = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = sts.slot_free;
         end
         ST_ERROR: begin
            cmd.emit_err = sts.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/rgb565_integer_upscaler.sv
// After a pixel transfer the sequencer steps through ST_POS and ST_EMIT, on the first
//   pixel of a frame through ST_SCALE, ST_BASE, ST_POS and ST_EMIT, on a bad geometry
//   through ST_SCALE and ST_ERROR. Writes leave from the output register; each pixel
//   yields scale*scale writes, one framebuffer write per cycle unless the output stalls,
//   and no pixel is taken until the loop ends; bad geometry yields one error write.
// Reset (synchronous, active high) clears geometry and position, selects buffer 1.
// ----------------------------------------------------------------------------
// rgb565_integer_upscaler
// Nearest-neighbor integer upscale of RGB565 pixels into centered RGB888
// framebuffer writes, with double-buffer select toggling per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_integer_upscaler
   import rgbup_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [PIX_BITS-1:0]      req_tdata,   // pixel_in
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,   // write_x, write_y, color_out
   output logic [RSP_USER_BITS-1:0]      rsp_tuser,   // buffer_select, error_flag, frame_done
   output logic                          rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   rgbup_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rgbup_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire
